[hdl/strict_priority_ticket_queues_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the strict priority ticket queues unit.
// Both macros are synchronous to the given clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_TICKET_QUEUES_UNIT_DEFINES_SVH
`define STRICT_PRIORITY_TICKET_QUEUES_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and operation codes of the strict priority ticket queues.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic [2:0] OP_ADD          = 3'd0;
	localparam logic [2:0] OP_SERVE_HIGHEST = 3'd1;
	localparam logic [2:0] OP_SERVE_CLASS  = 3'd2;
	localparam logic [2:0] OP_PEEK         = 3'd3;
	localparam logic [2:0] OP_COUNT        = 3'd4;
	localparam logic [2:0] OP_TOTAL        = 3'd5;

	typedef struct packed {
		logic [2:0] operation;
		logic [1:0] priority_class;
	} request_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        is_empty;
		logic        add_dropped;
		logic [1:0]  served_class;
	} response_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_ADD,
		CMD_SERVE_HIGH,
		CMD_SERVE_CLASS,
		CMD_PEEK,
		CMD_COUNT,
		CMD_TOTAL
	} cmd_kind_t;

	// Decoded command passed from the front end to the execution back end.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [1:0] cls;
		logic       cls_ok;
	} cmd_t;

endpackage

[hdl/strict_priority_ticket_queues_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_ticket_queues_unit
// Each request transaction yields exactly one response transaction, in
// request order. The unit issues ticket numbers from a wrapping 32-bit
// counter (the first ticket is 1) and keeps NUM_CLASSES FIFO queues of
// QUEUE_DEPTH tickets, class 0 having the highest priority. Add, count,
// total, unknown operations and serves or peeks that find their queue empty
// complete in the execute state of the back end; a serve or peek that
// returns a stored ticket also passes through the read state, because the
// ticket memory has one registered read port. A request is registered in
// the front-end command buffer before it reaches the back end, and its
// response is visible right after the edge that executes it. The ticket
// memory is not cleared after reset; only entries that were written are
// ever returned, so the unit accepts requests from the first cycle after
// reset.
// ----------------------------------------------------------------------------
module strict_priority_ticket_queues_unit
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int NUM_CLASSES = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	// Request side: a transaction is taken when push is high and full is low.
	input  logic      push,
	input  request_t  request,
	output logic      full,
	// Response side: the oldest response is shown while empty is low and is
	// taken when pop is high.
	output response_t response,
	output logic      empty,
	input  logic      pop
);

	// Decoded command between the front end and the back end. The front end
	// holds up to two commands, so it keeps accepting while the back end is
	// busy with a memory read or stalled by a full response buffer.
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	spq_front #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.request   (request),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// The back end owns all queue state and the ticket memory, and buffers
	// up to two responses so that execution continues while the consumer
	// holds off popping.
	spq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_CLASSES (NUM_CLASSES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.response  (response),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

[hdl/spq_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_fifo
// Two-entry first-in first-out buffer with registered full and empty flags.
// ----------------------------------------------------------------------------
module spq_fifo #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_data,
	output logic  empty
);

	item_t      slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign do_wr   = wr_en && (count_q != 2'd2);
	assign do_rd   = rd_en && (count_q != 2'd0);
	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[hdl/spq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_front
// Accepts request transactions, decodes the operation, checks the class
// and queues the decoded command for the back end.
// ----------------------------------------------------------------------------
module spq_front
	import spq_pkg::*;
#(
	parameter int NUM_CLASSES = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  request_t request,
	output logic     full,
	output cmd_t     cmd,
	output logic     cmd_valid,
	input  logic     cmd_pop
);

	cmd_t decoded;
	logic cmd_empty;

	always_comb begin
		decoded.cls    = request.priority_class;
		decoded.cls_ok = (32'(request.priority_class) < NUM_CLASSES);
		unique case (request.operation)
			OP_ADD:           decoded.kind = CMD_ADD;
			OP_SERVE_HIGHEST: decoded.kind = CMD_SERVE_HIGH;
			OP_SERVE_CLASS:   decoded.kind = CMD_SERVE_CLASS;
			OP_PEEK:          decoded.kind = CMD_PEEK;
			OP_COUNT:         decoded.kind = CMD_COUNT;
			OP_TOTAL:         decoded.kind = CMD_TOTAL;
			default:          decoded.kind = CMD_NONE;
		endcase
	end

	spq_fifo #(
		.item_t (cmd_t)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (decoded),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

[hdl/spq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_back
// Executes decoded commands against the ticket counter, the per-class head
// and fill registers and the ticket memory, and queues the responses.
// ----------------------------------------------------------------------------
`include "strict_priority_ticket_queues_unit_defines.svh"

module spq_back
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int NUM_CLASSES = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_pop,
	output response_t response,
	output logic      empty,
	input  logic      pop
);

	localparam int CW = $clog2(NUM_CLASSES);
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NUM_CLASSES * QUEUE_DEPTH);
	localparam int MEM_WORDS = NUM_CLASSES * QUEUE_DEPTH;

	typedef enum logic {
		ST_EXEC,
		ST_READ
	} state_t;

	state_t        state_q;
	logic [31:0]   ticket_q;
	logic [HW-1:0] head_q [NUM_CLASSES];
	logic [FW-1:0] fill_q [NUM_CLASSES];
	logic [TW-1:0] total_q;
	logic [1:0]    served_q;
	logic [31:0]   mem [MEM_WORDS];
	logic [31:0]   rdata_q;

	logic [NUM_CLASSES-1:0] nonempty;
	logic [CW-1:0]          pick;
	logic [CW-1:0]          cls_sel;
	logic [CW-1:0]          tgt;
	logic                   tgt_ok;
	logic                   add_ok;
	logic [HW:0]            tail_sum;
	logic [HW-1:0]          tail;
	logic [HW-1:0]          head_next;
	logic [31:0]            next_ticket;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic                   take;
	logic                   is_serve;
	logic                   needs_read;
	logic                   res_full;
	logic                   res_push;
	response_t              res_data;

	always_comb begin
		pick = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			nonempty[c] = (fill_q[c] != '0);
			if (fill_q[c] != '0) begin
				pick = CW'(c);
			end
		end
	end

	assign cls_sel     = cmd.cls_ok ? CW'(cmd.cls) : '0;
	assign is_serve    = (cmd.kind == CMD_SERVE_HIGH) || (cmd.kind == CMD_SERVE_CLASS);
	assign tgt         = (cmd.kind == CMD_SERVE_HIGH) ? pick : cls_sel;
	assign tgt_ok      = (cmd.kind == CMD_SERVE_HIGH) ? (|nonempty)
	                                                  : (cmd.cls_ok && nonempty[cls_sel]);
	assign add_ok      = cmd.cls_ok && (fill_q[cls_sel] != FW'(QUEUE_DEPTH));
	assign tail_sum    = (HW + 1)'(head_q[cls_sel]) + (HW + 1)'(fill_q[cls_sel]);
	assign tail        = (tail_sum >= (HW + 1)'(QUEUE_DEPTH))
	                     ? HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
	assign head_next   = (head_q[tgt] == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q[tgt] + HW'(1);
	assign next_ticket = ticket_q + 32'd1;
	assign wr_addr     = AW'(cls_sel) * AW'(QUEUE_DEPTH) + AW'(tail);
	assign rd_addr     = AW'(tgt) * AW'(QUEUE_DEPTH) + AW'(head_q[tgt]);
	assign take        = cmd_valid && (state_q == ST_EXEC) && !res_full;
	assign needs_read  = (is_serve || (cmd.kind == CMD_PEEK)) && tgt_ok;
	assign cmd_pop     = take;
	assign res_push    = (state_q == ST_READ) || (take && !needs_read);

	always_comb begin
		res_data = '0;
		if (state_q == ST_READ) begin
			res_data.result_value = rdata_q;
			res_data.served_class = served_q;
		end else begin
			case (cmd.kind)
				CMD_ADD: begin
					if (add_ok) begin
						res_data.result_value = next_ticket;
					end else begin
						res_data.add_dropped = 1'b1;
					end
				end
				CMD_SERVE_HIGH, CMD_SERVE_CLASS, CMD_PEEK: begin
					res_data.is_empty = 1'b1;
				end
				CMD_COUNT: begin
					if (cmd.cls_ok) begin
						res_data.result_value = 32'(fill_q[cls_sel]);
					end
					res_data.is_empty = !cmd.cls_ok || (fill_q[cls_sel] == '0);
				end
				CMD_TOTAL: begin
					res_data.result_value = 32'(total_q);
					res_data.is_empty     = (total_q == '0);
				end
				default: begin
					res_data = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_EXEC;
			ticket_q <= '0;
			total_q  <= '0;
			served_q <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				fill_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					if (take) begin
						if ((cmd.kind == CMD_ADD) && add_ok) begin
							ticket_q        <= next_ticket;
							fill_q[cls_sel] <= fill_q[cls_sel] + FW'(1);
							total_q         <= total_q + TW'(1);
						end
						if (is_serve && tgt_ok) begin
							head_q[tgt] <= head_next;
							fill_q[tgt] <= fill_q[tgt] - FW'(1);
							total_q     <= total_q - TW'(1);
							served_q    <= 2'(tgt);
						end else begin
							served_q <= '0;
						end
						if (needs_read) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				default: begin
					state_q <= ST_EXEC;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && (cmd.kind == CMD_ADD) && add_ok) begin
			mem[wr_addr] <= next_ticket;
		end
		rdata_q <= mem[rd_addr];
	end

	spq_fifo #(
		.item_t (response_t)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (response),
		.empty   (empty)
	);

	`SPQ_ASSERT_SAME(a_read_has_room, clk, arst_n, state_q == ST_READ, !res_full, "response buffer full while a memory read completes")
	`SPQ_ASSERT_NEXT(a_ticket_step, clk, arst_n, take && (cmd.kind == CMD_ADD) && add_ok, ticket_q == $past(ticket_q) + 32'd1, "ticket counter did not advance on an accepted add")
	`SPQ_ASSERT_NEXT(a_total_on_serve, clk, arst_n, take && is_serve && tgt_ok, total_q == $past(total_q) - TW'(1), "total count did not drop on a serve")

endmodule
